// ===== rtl/trc_pkg.sv =====
package trc_pkg;

    // Message layout
    localparam int MAX_SYMBOLS       = 12;
    localparam int SYM_W             = 2;
    localparam int MSG_W             = MAX_SYMBOLS * SYM_W;
    localparam int SYM_IDX_W         = 4;
    localparam int SYMBOLS_PER_FRAME = 12;

    // Register file
    localparam int PW_W       = 12;
    localparam int RC_W       = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int TICK_W     = 17;

    localparam logic [PW_W-1:0] PW_RESET = PW_W'(350);
    localparam logic [RC_W-1:0] RC_RESET = RC_W'(10);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PULSE_WIDTH  = 2'd0,
        CFG_REPEAT_COUNT = 2'd1
    } cfg_index_t;

    typedef enum logic [SYM_W-1:0] {
        SYM_ZERO    = 2'd0,
        SYM_ONE     = 2'd1,
        SYM_FLOAT   = 2'd2,
        SYM_INVALID = 2'd3
    } symbol_t;

    typedef enum logic [1:0] {
        STATUS_TICK        = 2'd0,
        STATUS_ACCEPTED    = 2'd1,
        STATUS_BAD_SYMBOL  = 2'd2,
        STATUS_BUSY        = 2'd3
    } status_t;

    typedef enum logic {
        MODE_START = 1'b0,
        MODE_TICK  = 1'b1
    } mode_t;

    typedef struct packed {
        logic    line_level;
        logic    busy_res;
        status_t status;
        logic    done_res;
    } trc_result_t;

    // Symbol i sits in bits (23-2i):(22-2i)
    function automatic symbol_t sym_at(input logic [MSG_W-1:0] msg,
                                       input logic [SYM_IDX_W-1:0] idx);
        logic [MSG_W-1:0] shifted;
        shifted = msg << ({1'b0, idx} << 1);
        return symbol_t'(shifted[MSG_W-1 -: SYM_W]);
    endfunction

endpackage

// ===== rtl/tristate_remote_code_encoder_unit.sv =====
// Tristate remote-code encoder for a 433 MHz transmitter line.
// Input channel (s_*): mode 0 starts a message of twelve 2-bit symbols
// (first symbol in bits 23:22); mode 1 is one time tick of the waveform.
// Result channel (m_*): one result per input transfer, carrying the line
// level for that tick, the busy flag after the item, a status code and a
// done flag on the last tick of the final frame repeat.
// Config channel (cfg_*): index 0 is the pulse width in ticks, index 1 the
// repeat count; write only while no item is in flight. A write during a
// transmission applies from the next tick on. cfg_ready is always high;
// unknown indexes are ignored.
// Timing: m_valid rises once the item has passed the input register, then
// the result register. Throughput: one item per cycle while the receiver
// takes results, as the waveform state machine steps once per item.
// Reset clears the control state: the block is idle with pulse width 350 and
// repeat count 10. When the receiver stalls, the result register holds and the
// input register fills; s_ready drops only when both are full.
module tristate_remote_code_encoder_unit import trc_pkg::*; #(
    parameter int SYMBOLS_PER_FRAME = trc_pkg::SYMBOLS_PER_FRAME
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_mode,
    input  logic [MSG_W-1:0]      s_symbols,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_line_level,
    output logic                  m_busy_res,
    output logic [1:0]            m_status,
    output logic                  m_done_res,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic              in_valid_reg;
    logic              in_mode_reg;
    logic [MSG_W-1:0]  in_symbols_reg;
    logic              out_valid_reg;
    trc_result_t       out_reg;
    logic [PW_W-1:0]   pw_reg;
    logic [RC_W-1:0]   rc_reg;
    logic              advance;
    trc_result_t       step_result;

    // Move the held item into the result register when there is room
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pw_reg <= PW_RESET;
            rc_reg <= RC_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_PULSE_WIDTH:  pw_reg <= cfg_data[PW_W-1:0];
                CFG_REPEAT_COUNT: rc_reg <= cfg_data[RC_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_mode_reg    <= s_mode;
            in_symbols_reg <= s_symbols;
        end
    end

    trc_core #(
        .SYMBOLS_PER_FRAME (SYMBOLS_PER_FRAME)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (advance),
        .mode         (in_mode_reg),
        .symbols      (in_symbols_reg),
        .pulse_width  (pw_reg),
        .repeat_count (rc_reg),
        .result       (step_result)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= step_result;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_line_level = out_reg.line_level;
    assign m_busy_res   = out_reg.busy_res;
    assign m_status     = out_reg.status;
    assign m_done_res   = out_reg.done_res;

endmodule

// ===== rtl/trc_core.sv =====
module trc_core import trc_pkg::*; #(
    parameter int SYMBOLS_PER_FRAME = trc_pkg::SYMBOLS_PER_FRAME
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  logic              mode,
    input  logic [MSG_W-1:0]  symbols,
    input  logic [PW_W-1:0]   pulse_width,
    input  logic [RC_W-1:0]   repeat_count,
    output trc_result_t       result
);

    localparam logic [SYM_IDX_W-1:0] LAST_COUNT = SYM_IDX_W'(SYMBOLS_PER_FRAME);

    logic [MSG_W-1:0]     msg_reg, msg_next;
    logic                 active_reg, active_next;
    logic [RC_W-1:0]      rep_idx_reg, rep_idx_next;
    logic [SYM_IDX_W-1:0] sym_idx_reg, sym_idx_next;
    logic                 bit_sel_reg, bit_sel_next;
    logic                 low_phase_reg, low_phase_next;
    logic                 in_sync_reg, in_sync_next;
    logic [TICK_W-1:0]    tick_reg, tick_next;

    logic [PW_W-1:0]      pw;
    logic [RC_W-1:0]      rc;
    logic [TICK_W-1:0]    pw1, pw3, pw31, hi_len, lo_len, len;
    logic [TICK_W-1:0]    tick_inc;
    logic [RC_W-1:0]      rep_inc;
    logic [SYM_IDX_W-1:0] sym_inc;
    symbol_t              cur_sym;
    logic                 bit_val;
    logic                 bad;

    // Phase lengths; zero settings act as one
    always_comb begin
        pw   = (pulse_width == '0) ? PW_W'(1) : pulse_width;
        rc   = (repeat_count == '0) ? RC_W'(1) : repeat_count;
        pw1  = TICK_W'(pw);
        pw3  = (pw1 << 1) + pw1;
        pw31 = (pw1 << 5) - pw1;
    end

    // Current bit of the frame
    always_comb begin
        cur_sym = sym_at(msg_reg, sym_idx_reg);
        bit_val = (cur_sym == SYM_ONE) || ((cur_sym == SYM_FLOAT) && bit_sel_reg);
        if (in_sync_reg) begin
            hi_len = pw1;
            lo_len = pw31;
        end else begin
            hi_len = bit_val ? pw3 : pw1;
            lo_len = bit_val ? pw1 : pw3;
        end
        len = low_phase_reg ? lo_len : hi_len;
    end

    // Scan the used symbol positions for an invalid code
    always_comb begin
        bad = 1'b0;
        for (int i = 0; i < SYMBOLS_PER_FRAME; i++) begin
            if (sym_at(symbols, SYM_IDX_W'(i)) == SYM_INVALID) begin
                bad = 1'b1;
            end
        end
    end

    assign tick_inc = tick_reg + TICK_W'(1);
    assign rep_inc  = rep_idx_reg + RC_W'(1);
    assign sym_inc  = sym_idx_reg + SYM_IDX_W'(1);

    // Step the waveform for one item
    always_comb begin
        msg_next       = msg_reg;
        active_next    = active_reg;
        rep_idx_next   = rep_idx_reg;
        sym_idx_next   = sym_idx_reg;
        bit_sel_next   = bit_sel_reg;
        low_phase_next = low_phase_reg;
        in_sync_next   = in_sync_reg;
        tick_next      = tick_reg;
        result.line_level = 1'b0;
        result.status     = STATUS_TICK;
        result.done_res   = 1'b0;

        if (mode == MODE_START) begin
            if (active_reg) begin
                result.status = STATUS_BUSY;
            end else if (bad) begin
                result.status = STATUS_BAD_SYMBOL;
            end else begin
                result.status  = STATUS_ACCEPTED;
                msg_next       = symbols;
                active_next    = 1'b1;
                rep_idx_next   = '0;
                sym_idx_next   = '0;
                bit_sel_next   = 1'b0;
                low_phase_next = 1'b0;
                in_sync_next   = 1'b0;
                tick_next      = '0;
            end
        end else if (active_reg) begin
            result.line_level = !low_phase_reg;
            tick_next         = tick_inc;
            if (tick_inc >= len) begin
                tick_next = '0;
                if (!low_phase_reg) begin
                    low_phase_next = 1'b1;
                end else begin
                    low_phase_next = 1'b0;
                    if (in_sync_reg) begin
                        in_sync_next = 1'b0;
                        rep_idx_next = rep_inc;
                        if (rep_inc >= rc) begin
                            result.done_res = 1'b1;
                            active_next     = 1'b0;
                            rep_idx_next    = '0;
                        end
                    end else if (!bit_sel_reg) begin
                        bit_sel_next = 1'b1;
                    end else begin
                        bit_sel_next = 1'b0;
                        sym_idx_next = sym_inc;
                        if (sym_inc >= LAST_COUNT) begin
                            sym_idx_next = '0;
                            in_sync_next = 1'b1;
                        end
                    end
                end
            end
        end
        result.busy_res = active_next;
    end

    // Commit state when an item is processed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            msg_reg       <= '0;
            active_reg    <= 1'b0;
            rep_idx_reg   <= '0;
            sym_idx_reg   <= '0;
            bit_sel_reg   <= 1'b0;
            low_phase_reg <= 1'b0;
            in_sync_reg   <= 1'b0;
            tick_reg      <= '0;
        end else if (step_en) begin
            msg_reg       <= msg_next;
            active_reg    <= active_next;
            rep_idx_reg   <= rep_idx_next;
            sym_idx_reg   <= sym_idx_next;
            bit_sel_reg   <= bit_sel_next;
            low_phase_reg <= low_phase_next;
            in_sync_reg   <= in_sync_next;
            tick_reg      <= tick_next;
        end
    end

endmodule

// ===== rtl/trc_checker.sv =====
module trc_checker import trc_pkg::*; (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_line_level,
    input logic       m_busy_res,
    input logic [1:0] m_status,
    input logic       m_done_res
);

    // No result right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // An accepted or busy-rejected start leaves a transmission running
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == STATUS_ACCEPTED || m_status == STATUS_BUSY)
            |-> m_busy_res)
        else $error("start result without busy");

    // Done only on a tick that ends the transmission
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> !m_busy_res && m_status == STATUS_TICK)
        else $error("done flag on a wrong result");

    // The line is low whenever the block is idle after the item
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_busy_res |-> !m_line_level)
        else $error("line high while idle");

endmodule

bind tristate_remote_code_encoder_unit trc_checker u_trc_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_line_level (m_line_level),
    .m_busy_res   (m_busy_res),
    .m_status     (m_status),
    .m_done_res   (m_done_res)
);
